@@ sv/lis_pkg.sv @@
// Shared types and constants for the longest increasing subsequence block.
// No dependencies; compiled first.
package lis_pkg;

    // Width of the reported subsequence length field.
    localparam int OUT_LEN_BITS = 7;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW_RD,
        ST_ROW_GET,
        ST_SCAN,
        ST_ROW_WR,
        ST_EMIT_RD,
        ST_EMIT_GET,
        ST_EMIT_OUT
    } lis_state_t;

endpackage

@@ sv/lis_if.sv @@
// Valid/ready channel interfaces for sample requests and result requests.
// Depends on lis_pkg for the length field width.
interface lis_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         final_item;

    modport source (output valid, output sample_value, output final_item, input ready);
    modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface lis_out_if
    import lis_pkg::*;
#(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] chosen_value;
    logic [OUT_LEN_BITS-1:0]      subsequence_length;
    logic                         run_end;

    modport source (output valid, output chosen_value, output subsequence_length,
                    output run_end, input ready);
    modport sink   (input valid, input chosen_value, input subsequence_length,
                    input run_end, output ready);
endinterface

@@ sv/longest_increasing_subsequence.sv @@
// Longest strictly increasing subsequence engine, quadratic DP over two memories.
// Depends on lis_pkg, lis_if.sv, lis_value_store and lis_dp_table.
//
// Usage:
//   samples carries one signed value per request; final_item closes the sequence.
//   Up to MAX_ITEMS values are kept, later ones are dropped (a dropped request
//   marked final still closes the sequence).  While loading, one request per cycle.
//   After the final request the DP pass walks rows n..0 (row 0 is a virtual start
//   below every value).  Row i scans positions i..n-1 with one value read and one
//   table read per cycle, as each memory has a single read port.
//   The subsequence is then emitted from the virtual start, one result request per
//   element, each carrying the total length and run_end on the last one.  A result
//   is read from both memories, then registered and offered; a stalled result is
//   held in the output register and the walk waits.  samples.ready is low from the
//   final request until it returns to loading after the last result is taken.
//   Reset clears the fill count and returns to loading; memory contents are not
//   cleared, as only entries written for the current sequence are ever read.
module longest_increasing_subsequence
    import lis_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    lis_in_if.sink    samples,
    lis_out_if.source results
);

    localparam int AW  = $clog2(MAX_ITEMS);      // value memory address
    localparam int CW  = $clog2(MAX_ITEMS + 1);  // counts, positions 0..MAX_ITEMS
    localparam int LW  = $clog2(MAX_ITEMS + 2);  // lengths up to MAX_ITEMS + 1
    localparam int DW  = LW + CW;                // {length, successor}

    lis_state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;     // values loaded so far
    logic [CW-1:0] n_reg, n_next;         // sequence length for this pass
    logic [CW-1:0] i_reg, i_next;         // current row, entry index
    logic [CW-1:0] j_reg, j_next;         // scan position (next to issue)
    logic          pipe_reg, pipe_next;   // read data of a scan step is due
    logic [LW-1:0] len_reg, len_next;     // best length of the current row
    logic [CW-1:0] succ_reg, succ_next;   // best successor of the current row
    logic [CW-1:0] total_reg, total_next; // subsequence length
    logic [CW-1:0] node_reg, node_next;   // walk position, entry index
    logic [CW-1:0] k_reg, k_next;         // results emitted
    logic signed [VALUE_BITS-1:0] vp_reg, vp_next;  // value at the row's position
    logic signed [VALUE_BITS-1:0] chosen_reg, chosen_next;
    logic          run_end_reg, run_end_next;

    // memory ports
    logic                         val_we;
    logic [AW-1:0]                val_waddr;
    logic [AW-1:0]                val_raddr;
    logic signed [VALUE_BITS-1:0] val_rdata;
    logic                         dp_we;
    logic [CW-1:0]                dp_waddr;
    logic [DW-1:0]                dp_wdata;
    logic [CW-1:0]                dp_raddr;
    logic [DW-1:0]                dp_rdata;
    logic [LW-1:0]                rd_len;
    logic [CW-1:0]                rd_succ;

    logic in_fire;
    logic has_room;
    logic issue;
    logic hit;

    assign rd_len   = dp_rdata[DW-1:CW];
    assign rd_succ  = dp_rdata[CW-1:0];
    assign in_fire  = samples.valid && samples.ready;
    assign has_room = (cnt_reg < CW'(MAX_ITEMS));
    assign issue    = (j_reg < n_reg);
    // Row 0 is the virtual start: every value is above it.
    assign hit      = pipe_reg && ((i_reg == '0) || (vp_reg < val_rdata))
                      && (rd_len >= len_reg);

    lis_value_store #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_values (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (samples.sample_value),
        .rd_addr (val_raddr),
        .rd_data (val_rdata)
    );

    lis_dp_table #(
        .DEPTH (MAX_ITEMS + 1),
        .AW    (CW),
        .DW    (DW)
    ) u_table (
        .clk     (clk),
        .wr_en   (dp_we),
        .wr_addr (dp_waddr),
        .wr_data (dp_wdata),
        .rd_addr (dp_raddr),
        .rd_data (dp_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && samples.final_item)
                begin
                    state_next = ST_ROW_RD;
                end
            end
            ST_ROW_RD:   state_next = ST_ROW_GET;
            ST_ROW_GET:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (!issue && !pipe_reg)
                begin
                    state_next = ST_ROW_WR;
                end
            end
            ST_ROW_WR:   state_next = (i_reg == '0) ? ST_EMIT_RD : ST_ROW_RD;
            ST_EMIT_RD:
            begin
                if ((node_reg == '0) || (k_reg == total_reg))
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_EMIT_GET;
                end
            end
            ST_EMIT_GET: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (results.ready)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pipe_next    = 1'b0;
        len_next     = len_reg;
        succ_next    = succ_reg;
        total_next   = total_reg;
        node_next    = node_reg;
        k_next       = k_reg;
        vp_next      = vp_reg;
        chosen_next  = chosen_reg;
        run_end_next = run_end_reg;
        val_we       = 1'b0;
        val_waddr    = cnt_reg[AW-1:0];
        val_raddr    = '0;
        dp_we        = 1'b0;
        dp_waddr     = i_reg;
        dp_wdata     = {len_reg, succ_reg};
        dp_raddr     = '0;
        samples.ready = 1'b0;
        results.valid = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                samples.ready = 1'b1;
                if (in_fire)
                begin
                    val_we = has_room;
                    if (samples.final_item)
                    begin
                        n_next   = has_room ? cnt_reg + CW'(1) : cnt_reg;
                        i_next   = n_next;
                        cnt_next = '0;
                    end
                    else if (has_room)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            ST_ROW_RD:
            begin
                val_raddr = (i_reg == '0) ? '0 : AW'(i_reg - CW'(1));
            end
            ST_ROW_GET:
            begin
                vp_next   = val_rdata;
                len_next  = LW'(1);
                succ_next = '0;
                j_next    = i_reg;
            end
            ST_SCAN:
            begin
                val_raddr = j_reg[AW-1:0];
                dp_raddr  = j_reg + CW'(1);
                pipe_next = issue;
                if (issue)
                begin
                    j_next = j_reg + CW'(1);
                end
                // j_reg already points one past the position whose data is due,
                // which is that position's entry index.
                if (hit)
                begin
                    len_next  = rd_len + LW'(1);
                    succ_next = j_reg;
                end
            end
            ST_ROW_WR:
            begin
                dp_we = 1'b1;
                if (i_reg == '0)
                begin
                    total_next = CW'(len_reg - LW'(1));
                    node_next  = succ_reg;
                    k_next     = '0;
                end
                else
                begin
                    i_next = i_reg - CW'(1);
                end
            end
            ST_EMIT_RD:
            begin
                val_raddr = AW'(node_reg - CW'(1));
                dp_raddr  = node_reg;
            end
            ST_EMIT_GET:
            begin
                chosen_next  = val_rdata;
                node_next    = rd_succ;
                run_end_next = ((k_reg + CW'(1)) == total_reg);
                k_next       = k_reg + CW'(1);
            end
            ST_EMIT_OUT:
            begin
                results.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign results.chosen_value       = chosen_reg;
    assign results.subsequence_length = OUT_LEN_BITS'(total_reg);
    assign results.run_end            = run_end_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            pipe_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pipe_reg  <= pipe_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        len_reg     <= len_next;
        succ_reg    <= succ_next;
        total_reg   <= total_next;
        node_reg    <= node_next;
        k_reg       <= k_next;
        vp_reg      <= vp_next;
        chosen_reg  <= chosen_next;
        run_end_reg <= run_end_next;
    end

    // Checks
    a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !samples.ready)
        else $error("sample request accepted while a result is pending");

    a_run_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.run_end) |=> !results.valid)
        else $error("result emitted after the run end");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (cnt_reg <= CW'(MAX_ITEMS)))
        else $error("fill count beyond capacity");

endmodule

@@ sv/lis_value_store.sv @@
// Sample value memory: one write port, one registered read port.
// No package dependencies.
module lis_value_store #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16,
    parameter int AW         = 6
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic signed [VALUE_BITS-1:0] wr_data,
    input  logic [AW-1:0]                rd_addr,
    output logic signed [VALUE_BITS-1:0] rd_data
);

    logic signed [VALUE_BITS-1:0] mem [MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/lis_dp_table.sv @@
// Length/successor table of the DP pass; entry 0 is the virtual start.
// One write port, one registered read port. No package dependencies.
module lis_dp_table #(
    parameter int DEPTH = 65,
    parameter int AW    = 7,
    parameter int DW    = 14
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ tb/longest_increasing_subsequence_test.sv @@
// Self-checking bench for longest_increasing_subsequence: random and directed sample requests,
// an inline predictor of the quadratic DP and the chain walk, result checks in order.
// Depends on lis_pkg, lis_if.sv and the block's RTL.
module longest_increasing_subsequence_test
    import lis_pkg::*;
();

    localparam int SAMPLE_BITS = 16;
    localparam int CAPACITY    = 64;
    localparam int TAIL_CYCLES = 50;

    // Value patterns for a random sequence.
    typedef enum int {
        FILL_WIDE,      // any 16-bit value
        FILL_NARROW,    // -4..4, lots of equal values and ties
        FILL_RISING     // upward trend with noise, long chains
    } fill_kind_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last;
    } sample_req_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] chain_value;
        logic [OUT_LEN_BITS-1:0]       chain_len;
        logic                          tail;
    } chain_elem_t;

    logic clk;
    logic rst_n;

    lis_in_if  #(.VALUE_BITS(SAMPLE_BITS)) samples_ch ();
    lis_out_if #(.VALUE_BITS(SAMPLE_BITS)) results_ch ();

    longest_increasing_subsequence #(
        .MAX_ITEMS  (CAPACITY),
        .VALUE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch)
    );

    // Requests waiting for the driver, chain elements waiting for the monitor.
    sample_req_t pending_samples[$];
    chain_elem_t expected_chain[$];

    // Predictor state: values of the open sequence, capped at CAPACITY.
    logic signed [SAMPLE_BITS-1:0] open_values[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int samples_taken = 0;
    int chains_closed = 0;
    int elems_checked = 0;
    int longest_chain = 0;

    sample_req_t next_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, several times the slowest expected run.
    initial
    begin
        #3000000;
        $display("timeout: %0d chain elements still expected", expected_chain.size());
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Absorb one accepted sample request. On the final request run the DP:
    // row i+1 holds the best chain starting at position i, row 0 is a virtual
    // start below every value. Strict compares keep the earliest successor on ties.
    task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic last);
        int          n;
        int          run_len[CAPACITY+1];
        int          run_next[CAPACITY+1];
        int          len;
        int          succ;
        int          total;
        int          node;
        chain_elem_t e;
        // dropped once the store is full, but a final still closes the sequence
        if (open_values.size() < CAPACITY)
            open_values.insert(open_values.size(), v);
        if (!last)
            return;
        n = open_values.size();
        for (int i = n; i >= 1; i--)
        begin
            len  = 1;
            succ = 0;
            for (int j = i; j < n; j++)
            begin
                if (open_values[i-1] < open_values[j] && run_len[j+1] + 1 > len)
                begin
                    len  = run_len[j+1] + 1;
                    succ = j + 1;
                end
            end
            run_len[i]  = len;
            run_next[i] = succ;
        end
        len  = 1;
        succ = 0;
        for (int j = 0; j < n; j++)
        begin
            if (run_len[j+1] + 1 > len)
            begin
                len  = run_len[j+1] + 1;
                succ = j + 1;
            end
        end
        total = len - 1;
        node  = succ;
        for (int k = 0; k < total; k++)
        begin
            e.chain_value = open_values[node-1];
            e.chain_len   = total[OUT_LEN_BITS-1:0];
            e.tail        = (k == total - 1);
            expected_chain.insert(expected_chain.size(), e);
            node = run_next[node];
        end
        if (total > longest_chain)
            longest_chain = total;
        chains_closed++;
        open_values.delete();
    endtask

    task automatic check_result();
        chain_elem_t e;
        if (expected_chain.size() == 0)
        begin
            report_mismatch($sformatf("result request %0d with nothing expected",
                                      results_ch.chosen_value));
            return;
        end
        e = expected_chain.pop_front();
        elems_checked++;
        if (results_ch.chosen_value !== e.chain_value)
            report_mismatch($sformatf("chosen_value %0d, expected %0d",
                                      results_ch.chosen_value, e.chain_value));
        if (results_ch.subsequence_length !== e.chain_len)
            report_mismatch($sformatf("subsequence_length %0d, expected %0d",
                                      results_ch.subsequence_length, e.chain_len));
        if (results_ch.run_end !== e.tail)
            report_mismatch($sformatf("run_end %0b, expected %0b",
                                      results_ch.run_end, e.tail));
    endtask

    // Driver: a new request goes out once the current one is taken.
    // valid gets at most one assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_ch.valid        <= 1'b0;
            samples_ch.sample_value <= '0;
            samples_ch.final_item   <= 1'b0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                samples_taken++;
                absorb_sample(samples_ch.sample_value, samples_ch.final_item);
            end
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_samples.pop_front();
                    samples_ch.valid        <= 1'b1;
                    samples_ch.sample_value <= next_req.value;
                    samples_ch.final_item   <= next_req.last;
                end
                else
                    samples_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, check every taken result request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else
        begin
            if (results_ch.valid && results_ch.ready)
                check_result();
            results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_sample(input int v, input bit last);
        sample_req_t r;
        r.value = v[SAMPLE_BITS-1:0];
        r.last  = last;
        pending_samples.insert(pending_samples.size(), r);
    endtask

    task automatic queue_sequence(input int len, input fill_kind_t kind);
        int v;
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                FILL_WIDE:   v = int'($urandom());
                FILL_NARROW: v = int'($urandom_range(8)) - 4;
                default:     v = k * 700 - 20000 + int'($urandom_range(1200)) - 600;
            endcase
            push_sample(v, k == len - 1);
        end
    endtask

    // Mostly short sequences; a few longer ones keep the DP pass cheap overall.
    task automatic queue_random_phase(input int quota);
        int sent;
        int len;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(7) == 0)
                len = $urandom_range(24, 9);
            else
                len = $urandom_range(8, 1);
            queue_sequence(len, fill_kind_t'($urandom_range(2)));
            sent += len;
        end
    endtask

    // Sender holds off until every queued request is taken and every
    // expected result has arrived; also serves as the full-drain pause.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || samples_ch.valid || expected_chain.size() != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase 1: sender mostly busy, receiver stalls often.
        send_idle_pct = 15;
        recv_idle_pct = 75;

        // single element, most negative value
        push_sample(-32768, 1'b1);
        // falling pair: both chains of length 1, earliest wins
        push_sample(32767, 1'b0);
        push_sample(-32768, 1'b1);
        // strictly rising across the whole range
        push_sample(-32768, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(0, 1'b0);
        push_sample(1, 1'b0);
        push_sample(32767, 1'b1);
        // equal values never extend a chain
        push_sample(5, 1'b0);
        push_sample(5, 1'b0);
        push_sample(5, 1'b1);
        // best chain does not start at position 0
        push_sample(3, 1'b0);
        push_sample(1, 1'b0);
        push_sample(2, 1'b1);
        // tie between two successors of equal length
        push_sample(0, 1'b0);
        push_sample(9, 1'b0);
        push_sample(7, 1'b1);
        drain();

        queue_random_phase(12);
        drain();

        // Phase 2: roles swapped.
        send_idle_pct = 75;
        recv_idle_pct = 15;
        queue_random_phase(12);
        drain();

        // Phase 3: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(10);
        // full store: 64 rising values, then a dropped request and a dropped final
        for (int k = 0; k < CAPACITY; k++)
            push_sample(-32000 + k * 1000 + int'($urandom_range(500)), 1'b0);
        push_sample(int'($urandom_range(1000)) - 32768, 1'b0);
        push_sample(32767, 1'b1);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_chain.size() != 0)
            report_mismatch($sformatf("%0d chain elements never arrived", expected_chain.size()));

        $display("covered %0d sequences from %0d sample requests, %0d result requests checked",
                 chains_closed, samples_taken, elems_checked);
        $display("longest chain %0d, including a full store with dropped requests",
                 longest_chain);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
